### sv/rao_pkg.sv
// Shared types, constants and substitution functions for the rotating
// alphabet obfuscator. No dependencies.
package rao_pkg;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = CMD_PTR_W + 1;

  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [6:0]  ALPHA_LEN  = 7'd77;
  localparam logic [11:0] USER_MASK  = 12'hf5f;
  localparam logic [3:0]  SLICE_LAST = 4'd9;

  localparam logic [20:0] TIME_BIAS    = 21'd423793;
  localparam logic [20:0] TIME_WRAP_LO = TIME_BIAS + 21'd65535;

  localparam logic [7:0] CHR_DOT       = 8'h2e;
  localparam logic [7:0] CHR_KEY_LO    = 8'h65;
  localparam logic [7:0] CHR_KEY_HI    = 8'h74;
  localparam logic [7:0] CHR_HDR_BASE  = 8'h53;
  localparam logic [7:0] CHR_TIME_BASE = 8'h61;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_KEY   = 3'd6;
  localparam logic [2:0] PH_BODY  = 3'd7;

  localparam logic [2:0] ENC_STEP_DOT   = 3'd0;
  localparam logic [2:0] ENC_STEP_NONCE = 3'd6;
  localparam logic [2:0] ENC_STEP_BYTE  = 3'd7;
  localparam logic [2:0] KEY_REC_LAST   = 3'd4;
  localparam logic [2:0] KEY_POS        = 3'd6;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FORMAT = 2'd1;
  localparam logic [1:0] STAT_CHECK  = 2'd2;

  localparam logic [31:0] SEQ_WORDS [16] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'h698098d8,
    32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a, 32'ha8304613,
    32'h774696ea, 32'h6720696e, 32'h3a257320, 32'h6f75743a,
    32'h73656320, 32'h6f74202e, 32'h203d640a, 32'h6e6f742e
  };

  typedef enum logic [2:0] {
    CMD_ENC_START,
    CMD_ENC_BODY,
    CMD_DEC_STORE,
    CMD_DEC_SHORT,
    CMD_DEC_KEY,
    CMD_DEC_BODY
  } cmd_kind_e;

  typedef enum logic [1:0] {
    REG_DECODE_MODE,
    REG_EXTRA_KEY,
    REG_USER_KEY,
    REG_TIME_STAMP
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BS_DISPATCH,
    BS_ENC,
    BS_KEY_REC,
    BS_KEY_SUM,
    BS_KEY_CMP,
    BS_FLUSH
  } back_st_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic [3:0] nonce;
    logic [2:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic        decode_mode;
    logic [15:0] extra_key;
    logic [11:0] user_key;
    logic [15:0] time_stamp;
  } cfg_t;

  function automatic logic [6:0] alpha_mod(input logic [16:0] x);
    logic [11:0] r1;
    logic [9:0]  r2;
    r1 = 12'(x[16:10]) * 12'd23 + 12'(x[9:0]);
    r2 = 10'(r1[11:8]) * 10'd25 + 10'(r1[7:0]);
    if (r2 >= 10'd308) r2 = r2 - 10'd308;
    if (r2 >= 10'd154) r2 = r2 - 10'd154;
    if (r2 >= 10'd154) r2 = r2 - 10'd154;
    if (r2 >= 10'd77)  r2 = r2 - 10'd77;
    return r2[6:0];
  endfunction

  function automatic logic [3:0] slice_next(input logic [3:0] s);
    return (s >= SLICE_LAST) ? 4'd0 : s + 4'd1;
  endfunction

  function automatic logic [4:0] slice_bits(input logic [31:0] w, input logic [3:0] s);
    logic [4:0] r;
    case (s)
      4'd0:    r = w[4:0];
      4'd1:    r = w[7:3];
      4'd2:    r = w[10:6];
      4'd3:    r = w[13:9];
      4'd4:    r = w[16:12];
      4'd5:    r = w[19:15];
      4'd6:    r = w[22:18];
      4'd7:    r = w[25:21];
      4'd8:    r = w[28:24];
      4'd9:    r = w[31:27];
      default: r = w[4:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] subst(input logic [7:0] b, input logic back,
                                       input logic [3:0] ws, input logic [3:0] s,
                                       input logic [6:0] kmod);
    logic [7:0] off_sum;
    logic [6:0] off;
    logic [6:0] shift;
    logic [6:0] idx;
    logic       valid;
    logic [7:0] t;
    logic [7:0] r;
    off_sum = 8'(slice_bits(SEQ_WORDS[ws], s)) + 8'(kmod);
    off     = (off_sum >= 8'(ALPHA_LEN)) ? 7'(off_sum - 8'(ALPHA_LEN)) : off_sum[6:0];
    shift   = back ? ALPHA_LEN - off : off;
    valid   = 1'b1;
    idx     = '0;
    if (b inside {[8'h30:8'h39]}) begin
      idx = 7'(b - 8'h30);
    end else if (b inside {[8'h41:8'h5a]}) begin
      idx = 7'(b - 8'h37);
    end else if (b inside {[8'h61:8'h7a]}) begin
      idx = 7'(b - 8'h3d);
    end else if (b inside {[8'h21:8'h2f]}) begin
      idx = 7'(b + 8'd29);
    end else begin
      valid = 1'b0;
    end
    t = 8'(idx) + 8'(shift);
    if (t >= 8'(ALPHA_LEN)) t = t - 8'(ALPHA_LEN);
    if (!valid) begin
      r = b;
    end else if (t < 8'd10) begin
      r = t + 8'h30;
    end else if (t < 8'd36) begin
      r = t + 8'h37;
    end else if (t < 8'd62) begin
      r = t + 8'h3d;
    end else begin
      r = t - 8'd29;
    end
    return r;
  endfunction

endpackage

### sv/rao_cfg.sv
// Configuration registers behind the APB-style port, plus the registered
// key sum reduced over the alphabet. Depends on rao_pkg.
module rao_cfg import rao_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]           pwdata_i,
  output logic [31:0]           prdata_o,
  output logic                  pready_o,
  output cfg_t                  cfg_o,
  output logic [6:0]            key_mod_o
);

  cfg_t       cfg_q;
  logic [6:0] key_mod_q;
  logic       wr_en;
  cfg_reg_e   reg_sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_sel  = cfg_reg_e'(paddr_i[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      key_mod_q <= '0;
    end else begin
      if (wr_en) begin
        case (reg_sel)
          REG_DECODE_MODE: cfg_q.decode_mode <= pwdata_i[0];
          REG_EXTRA_KEY:   cfg_q.extra_key   <= pwdata_i[15:0];
          REG_USER_KEY:    cfg_q.user_key    <= pwdata_i[11:0];
          REG_TIME_STAMP:  cfg_q.time_stamp  <= pwdata_i[15:0];
          default:         cfg_q             <= cfg_q;
        endcase
      end
      key_mod_q <= alpha_mod(17'(cfg_q.extra_key) + 17'(cfg_q.user_key & USER_MASK));
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DECODE_MODE: prdata_o = 32'(cfg_q.decode_mode);
      REG_EXTRA_KEY:   prdata_o = 32'(cfg_q.extra_key);
      REG_USER_KEY:    prdata_o = 32'(cfg_q.user_key);
      REG_TIME_STAMP:  prdata_o = 32'(cfg_q.time_stamp);
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o     = cfg_q;
  assign key_mod_o = key_mod_q;

endmodule

### sv/rao_front.sv
// Front end: accepts input bytes, tracks the string phase, classifies each
// byte into a command and queues it for the back end. Depends on rao_pkg.
module rao_front import rao_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  input  logic [3:0] nonce_i,
  input  logic       decode_mode_i,
  output cmd_t       cmd_o,
  output logic       cmd_valid_o,
  input  logic       cmd_pop_i
);

  logic [2:0]           phase_q, phase_d;
  cmd_t                 new_cmd;
  cmd_t                 q_mem [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_q, rd_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 accept;
  logic                 zero;

  assign full_o      = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];
  assign zero        = (in_byte_i == '0);

  always_comb begin
    new_cmd.kind  = CMD_ENC_BODY;
    new_cmd.data  = in_byte_i;
    new_cmd.nonce = nonce_i;
    new_cmd.pos   = phase_q;
    phase_d       = zero ? PH_START : PH_BODY;
    if (!decode_mode_i) begin
      new_cmd.kind = (phase_q == PH_START) ? CMD_ENC_START : CMD_ENC_BODY;
    end else if (phase_q < PH_KEY) begin
      if (zero) begin
        new_cmd.kind = CMD_DEC_SHORT;
      end else begin
        new_cmd.kind = CMD_DEC_STORE;
        phase_d      = phase_q + 3'd1;
      end
    end else if (phase_q == PH_KEY) begin
      new_cmd.kind = CMD_DEC_KEY;
    end else begin
      new_cmd.kind = CMD_DEC_BODY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        wr_q    <= wr_q + CMD_PTR_W'(1);
      end
      if (cmd_pop_i) begin
        rd_q <= rd_q + CMD_PTR_W'(1);
      end
      if (accept && !cmd_pop_i) begin
        cnt_q <= cnt_q + CMD_CNT_W'(1);
      end else if (!accept && cmd_pop_i) begin
        cnt_q <= cnt_q - CMD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_q] <= new_cmd;
    end
  end

endmodule

### sv/rao_back.sv
// Back end: sequences queued commands through the substitution unit, the
// prologue store and the header check, and queues the results. Depends on rao_pkg.
module rao_back import rao_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_pop_o,
  input  logic [15:0] time_stamp_i,
  input  logic [6:0]  key_mod_i,
  output logic        empty_o,
  input  logic        pop_i,
  output res_t        res_o
);

  back_st_e   st_q, st_d;
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] last_q, last_d;
  logic [3:0] slice_q, slice_d;
  logic [3:0] ws_q, ws_d;
  logic       verb_q, verb_d;
  logic [1:0] err_q, err_d;
  logic       dot_q, dot_d;
  logic [20:0] sum_q, sum_d;
  logic       h0ok_q, h0ok_d;
  logic [7:0] store_q [7];
  logic [7:0] h_q [5];

  logic       room;
  logic       emit;
  res_t       res_d;
  logic [7:0] sub_in;
  logic       sub_back;
  logic       sub_adv;
  logic [7:0] sub_out;
  logic       store_we;
  logic [2:0] store_wa;
  logic [2:0] rd_idx;
  logic [7:0] rd_byte;
  logic       h_we;
  logic [7:0] hdr;
  logic [20:0] time_ref;
  logic       bad;
  logic       key_ok;

  res_t                 rq_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] rq_wr_q, rq_rd_q;
  logic [RES_CNT_W-1:0] rq_cnt_q;
  logic                 rq_pop;

  assign room     = (rq_cnt_q != RES_CNT_W'(RES_DEPTH));
  assign empty_o  = (rq_cnt_q == '0);
  assign rq_pop   = pop_i && !empty_o;
  assign res_o    = rq_mem[rq_rd_q];
  assign rd_byte  = store_q[rd_idx];
  assign sub_out  = subst(sub_in, sub_back, ws_q, slice_q, key_mod_i);
  assign time_ref = 21'(time_stamp_i) + TIME_BIAS;
  assign key_ok   = cmd_i.data inside {[CHR_KEY_LO:CHR_KEY_HI]};

  always_comb begin
    case (cnt_q)
      3'd1:    hdr = CHR_HDR_BASE - {4'b0, cmd_i.nonce[2:0], 1'b0};
      3'd2:    hdr = CHR_TIME_BASE + {4'b0, time_stamp_i[7:4]};
      3'd3:    hdr = CHR_TIME_BASE + {4'b0, time_stamp_i[3:0]};
      3'd4:    hdr = CHR_TIME_BASE + {4'b0, time_stamp_i[15:12]};
      3'd5:    hdr = CHR_TIME_BASE + {4'b0, time_stamp_i[11:8]};
      default: hdr = cmd_i.data;
    endcase
  end

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    slice_d   = slice_q;
    ws_d      = ws_q;
    verb_d    = verb_q;
    err_d     = err_q;
    dot_d     = dot_q;
    sum_d     = sum_q;
    h0ok_d    = h0ok_q;
    emit      = 1'b0;
    res_d     = '0;
    sub_in    = cmd_i.data;
    sub_back  = 1'b0;
    sub_adv   = 1'b0;
    store_we  = 1'b0;
    store_wa  = cmd_i.pos;
    rd_idx    = '0;
    h_we      = 1'b0;
    cmd_pop_o = 1'b0;
    bad       = 1'b0;

    case (st_q)
      BS_DISPATCH: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_ENC_START: begin
              ws_d    = cmd_i.nonce;
              slice_d = '0;
              verb_d  = 1'b0;
              err_d   = STAT_OK;
              cnt_d   = ENC_STEP_DOT;
              st_d    = BS_ENC;
            end
            CMD_ENC_BODY: begin
              if (room) begin
                emit      = 1'b1;
                sub_adv   = 1'b1;
                res_d     = '{sub_out, cmd_i.data == '0, STAT_OK};
                cmd_pop_o = 1'b1;
              end
            end
            CMD_DEC_STORE: begin
              store_we  = 1'b1;
              cmd_pop_o = 1'b1;
              if (cmd_i.pos == PH_START) begin
                dot_d = (cmd_i.data == CHR_DOT);
              end
            end
            CMD_DEC_SHORT: begin
              store_we = 1'b1;
              err_d    = STAT_FORMAT;
              verb_d   = 1'b0;
              cnt_d    = '0;
              last_d   = cmd_i.pos;
              st_d     = BS_FLUSH;
            end
            CMD_DEC_KEY: begin
              store_we = 1'b1;
              store_wa = KEY_POS;
              cnt_d    = '0;
              if (key_ok) begin
                ws_d    = 4'(cmd_i.data - CHR_KEY_LO);
                slice_d = '0;
                st_d    = BS_KEY_REC;
              end else begin
                err_d  = STAT_FORMAT;
                verb_d = 1'b1;
                last_d = KEY_POS;
                st_d   = BS_FLUSH;
              end
            end
            CMD_DEC_BODY: begin
              if (room) begin
                emit      = 1'b1;
                sub_back  = 1'b1;
                sub_adv   = !verb_q;
                res_d     = '{verb_q ? cmd_i.data : sub_out, cmd_i.data == '0, err_q};
                cmd_pop_o = 1'b1;
              end
            end
            default: st_d = BS_DISPATCH;
          endcase
        end
      end
      BS_ENC: begin
        sub_in = hdr;
        if (room) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == ENC_STEP_DOT) begin
            res_d = '{CHR_DOT, 1'b0, STAT_OK};
          end else if (cnt_q == ENC_STEP_NONCE) begin
            res_d = '{CHR_KEY_LO + {4'b0, cmd_i.nonce}, 1'b0, STAT_OK};
          end else begin
            sub_adv = 1'b1;
            res_d   = '{sub_out, (cnt_q == ENC_STEP_BYTE) && (cmd_i.data == '0), STAT_OK};
          end
          if (cnt_q == ENC_STEP_BYTE) begin
            cmd_pop_o = 1'b1;
            st_d      = BS_DISPATCH;
          end
        end
      end
      BS_KEY_REC: begin
        rd_idx   = cnt_q + 3'd1;
        sub_in   = rd_byte;
        sub_back = 1'b1;
        sub_adv  = 1'b1;
        h_we     = 1'b1;
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == KEY_REC_LAST) begin
          st_d = BS_KEY_SUM;
        end
      end
      BS_KEY_SUM: begin
        sum_d  = (21'(h_q[3]) << 12) + (21'(h_q[4]) << 8) + (21'(h_q[1]) << 4)
               + 21'(h_q[2]);
        h0ok_d = (h_q[0] == CHR_HDR_BASE - {4'b0, ws_q[2:0], 1'b0});
        st_d   = BS_KEY_CMP;
      end
      BS_KEY_CMP: begin
        bad = !dot_q || !h0ok_q || ((sum_q != time_ref) && (sum_q != time_ref - 21'd1));
        if (((time_stamp_i == '0) && (sum_q == TIME_WRAP_LO)) ||
            ((time_stamp_i == 16'hffff) && (sum_q == TIME_BIAS))) begin
          bad = 1'b0;
        end
        if (bad) begin
          err_d  = STAT_CHECK;
          verb_d = 1'b1;
          cnt_d  = '0;
          last_d = KEY_POS;
          st_d   = BS_FLUSH;
        end else begin
          err_d     = STAT_OK;
          verb_d    = 1'b0;
          cmd_pop_o = 1'b1;
          st_d      = BS_DISPATCH;
        end
      end
      BS_FLUSH: begin
        rd_idx = cnt_q;
        if (room) begin
          emit  = 1'b1;
          res_d = '{rd_byte, rd_byte == '0, err_q};
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == last_q) begin
            cmd_pop_o = 1'b1;
            st_d      = BS_DISPATCH;
          end
        end
      end
      default: st_d = BS_DISPATCH;
    endcase

    if (sub_adv) begin
      slice_d = slice_next(slice_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BS_DISPATCH;
      cnt_q    <= '0;
      last_q   <= '0;
      slice_q  <= '0;
      ws_q     <= '0;
      verb_q   <= 1'b0;
      err_q    <= STAT_OK;
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      slice_q <= slice_d;
      ws_q    <= ws_d;
      verb_q  <= verb_d;
      err_q   <= err_d;
      if (emit) begin
        rq_wr_q <= rq_wr_q + RES_PTR_W'(1);
      end
      if (rq_pop) begin
        rq_rd_q <= rq_rd_q + RES_PTR_W'(1);
      end
      if (emit && !rq_pop) begin
        rq_cnt_q <= rq_cnt_q + RES_CNT_W'(1);
      end else if (!emit && rq_pop) begin
        rq_cnt_q <= rq_cnt_q - RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q  <= dot_d;
    sum_q  <= sum_d;
    h0ok_q <= h0ok_d;
    if (store_we) begin
      store_q[store_wa] <= cmd_i.data;
    end
    if (h_we) begin
      h_q[cnt_q] <= sub_out;
    end
    if (emit) begin
      rq_mem[rq_wr_q] <= res_d;
    end
  end

  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("command popped from an empty queue");

  a_key_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BS_KEY_REC || st_q == BS_KEY_SUM || st_q == BS_KEY_CMP)
      |-> (cmd_valid_i && cmd_i.kind == CMD_DEC_KEY))
    else $error("key check running without a key command at the head");

  a_rec_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BS_KEY_REC && cnt_q == KEY_REC_LAST) |=> (st_q == BS_KEY_SUM))
    else $error("header recovery did not hand over to the time sum");

  a_slice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slice_q <= SLICE_LAST)
    else $error("slice index out of range");

  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BS_FLUSH) |-> (last_q <= KEY_POS && cnt_q <= last_q))
    else $error("prologue flush ran past the stored bytes");

endmodule

### sv/rotating_alphabet_obfuscator.sv
// Top level of the rotating alphabet obfuscator: configuration port, front
// end and back end. Depends on rao_pkg, rao_cfg, rao_front and rao_back.
//
//   channel  handshake                      payload
//   config   psel/penable/pwrite/pready     paddr, pwdata, prdata
//   input    push, full                     in_byte_i, nonce_i
//   result   empty, pop                     out_byte_o, end_of_string_o, status_o
//
// Body bytes run at one per cycle; a result reaches the ports through the command
// queue and the result queue. An encode string start holds the back end for a setup
// step plus 8 results. A decode key letter in range runs header recovery, the time
// sum and the compare; out of range or failing the check, it replays the stored bytes.
// Other prologue bytes give no result; a zero among them replays them, one per cycle.
// full rises when the 4-entry command queue fills; the back end stalls only
// on a full 8-entry result queue. Reset clears the queues and string state.
module rotating_alphabet_obfuscator import rao_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_byte_i,
  input  logic [3:0]            nonce_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte_o,
  output logic                  end_of_string_o,
  output logic [1:0]            status_o
);

  cfg_t       cfg;
  logic [6:0] key_mod;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;
  res_t       res;

  rao_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg),
    .key_mod_o (key_mod)
  );

  rao_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .in_byte_i     (in_byte_i),
    .nonce_i       (nonce_i),
    .decode_mode_i (cfg.decode_mode),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop)
  );

  rao_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .time_stamp_i (cfg.time_stamp),
    .key_mod_i    (key_mod),
    .empty_o      (empty),
    .pop_i        (pop),
    .res_o        (res)
  );

  assign out_byte_o      = res.out_byte;
  assign end_of_string_o = res.end_of_string;
  assign status_o        = res.status;

endmodule

### test/rao_result_checker.sv
`timescale 1ns / 1ps
// Result checker for rotating_alphabet_obfuscator: tracks register writes and
// byte transfers, predicts every produced byte and compares it. Uses rao_pkg.
module rao_result_checker import rao_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  push,
  input  logic                  full,
  input  logic [7:0]            sent_byte_i,
  input  logic [3:0]            sent_nonce_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [7:0]            got_byte_i,
  input  logic                  got_eos_i,
  input  logic [1:0]            got_status_i,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    ok_cnt_o,
  output int                    format_cnt_o,
  output int                    check_cnt_o
);

  localparam int         ALPHABET  = 77;
  localparam logic [11:0] UKEY_MASK = 12'hf5f;
  localparam logic [2:0] SEG_START = 3'd0;
  localparam logic [2:0] SEG_KEY   = 3'd6;
  localparam logic [2:0] SEG_BODY  = 3'd7;
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_CHECK  = "S";
  localparam logic [7:0] CH_TIME   = "a";
  localparam logic [7:0] CH_KEY_LO = "e";
  localparam logic [7:0] CH_KEY_HI = "t";

  localparam logic [31:0] KEY_WORDS [16] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'h698098d8,
    32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a, 32'ha8304613,
    32'h774696ea, 32'h6720696e, 32'h3a257320, 32'h6f75743a,
    32'h73656320, 32'h6f74202e, 32'h203d640a, 32'h6e6f742e
  };

  logic        mode_q;
  logic [15:0] extra_q;
  logic [11:0] user_q;
  logic [15:0] stamp_q;
  logic [2:0]  phase_q;
  logic [3:0]  slice_q;
  logic [3:0]  word_q;
  logic [7:0]  prologue_q [7];
  logic        verbatim_q;
  logic [1:0]  err_q;

  res_t due_results [$];
  res_t oldest;
  int   fail_cnt;
  int   checked;
  int   ok_cnt;
  int   format_cnt;
  int   check_cnt;

  function automatic int sym_index(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "A" && b <= "Z") return int'(b - "A") + 10;
    if (b >= "a" && b <= "z") return int'(b - "a") + 36;
    if (b >= "!" && b <= "/") return int'(b - "!") + 62;
    return -1;
  endfunction

  function automatic logic [7:0] sym_char(input int i);
    if (i < 10) return "0" + 8'(i);
    if (i < 36) return "A" + 8'(i - 10);
    if (i < 62) return "a" + 8'(i - 36);
    return "!" + 8'(i - 62);
  endfunction

  function automatic logic [7:0] rotate_sym(input logic [7:0] b, input bit back);
    int s;
    int off;
    int i;
    s = (slice_q > 4'd9) ? 0 : int'(slice_q);
    off = int'((KEY_WORDS[word_q] >> (3 * s)) & 32'h1f) + int'(extra_q)
        + int'(user_q & UKEY_MASK);
    slice_q = (s >= 9) ? 4'd0 : 4'(s + 1);
    off = off % ALPHABET;
    i = sym_index(b);
    if (i < 0) return b;
    if (back) return sym_char((i + ALPHABET - off) % ALPHABET);
    return sym_char((i + off) % ALPHABET);
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic eos,
                                     input logic [1:0] st);
    res_t r;
    r.out_byte      = b;
    r.end_of_string = eos;
    r.status        = st;
    due_results.push_back(r);
  endfunction

  function automatic void replay_prologue(input int count, input logic [1:0] st);
    for (int k = 0; k < count && k < 7; k++) begin
      queue_byte(prologue_q[k], prologue_q[k] == 8'd0, st);
    end
  endfunction

  function automatic void derive_results(input logic [7:0] b, input logic [3:0] n);
    logic [7:0] hdr [5];
    logic [7:0] h [5];
    logic [3:0] key;
    int         enc;
    int         tv;
    bit         bad;
    if (!mode_q) begin
      if (phase_q == SEG_START) begin
        word_q     = n;
        slice_q    = 4'd0;
        verbatim_q = 1'b0;
        err_q      = STAT_OK;
        hdr[0] = CH_CHECK - 8'(2 * n[2:0]);
        hdr[1] = CH_TIME + 8'(stamp_q[7:4]);
        hdr[2] = CH_TIME + 8'(stamp_q[3:0]);
        hdr[3] = CH_TIME + 8'(stamp_q[15:12]);
        hdr[4] = CH_TIME + 8'(stamp_q[11:8]);
        queue_byte(CH_DOT, 1'b0, STAT_OK);
        for (int k = 0; k < 5; k++) queue_byte(rotate_sym(hdr[k], 1'b0), 1'b0, STAT_OK);
        queue_byte(CH_KEY_LO + 8'(n), 1'b0, STAT_OK);
      end
      queue_byte(rotate_sym(b, 1'b0), b == 8'd0, STAT_OK);
      phase_q = (b == 8'd0) ? SEG_START : SEG_BODY;
    end else if (phase_q < SEG_KEY) begin
      prologue_q[phase_q] = b;
      if (b == 8'd0) begin
        err_q      = STAT_FORMAT;
        verbatim_q = 1'b0;
        replay_prologue(int'(phase_q) + 1, STAT_FORMAT);
        phase_q = SEG_START;
      end else begin
        phase_q = phase_q + 3'd1;
      end
    end else if (phase_q == SEG_KEY) begin
      prologue_q[6] = b;
      if (b < CH_KEY_LO || b > CH_KEY_HI) begin
        err_q = STAT_FORMAT;
      end else begin
        key     = 4'(b - CH_KEY_LO);
        word_q  = key;
        slice_q = 4'd0;
        for (int k = 0; k < 5; k++) h[k] = rotate_sym(prologue_q[k + 1], 1'b1);
        bad = (prologue_q[0] != CH_DOT) || (h[0] != CH_CHECK - 8'(2 * key[2:0]));
        enc = (int'(h[1]) - int'(CH_TIME)) * 16 + (int'(h[2]) - int'(CH_TIME))
            + (int'(h[3]) - int'(CH_TIME)) * 4096 + (int'(h[4]) - int'(CH_TIME)) * 256;
        tv = int'(stamp_q);
        if (enc != tv && enc != tv - 1) bad = 1'b1;
        if ((tv == 0 && enc == 65535) || (tv == 65535 && enc == 0)) bad = 1'b0;
        err_q = bad ? STAT_CHECK : STAT_OK;
      end
      if (err_q != STAT_OK) begin
        replay_prologue(7, err_q);
        verbatim_q = 1'b1;
        phase_q    = (b == 8'd0) ? SEG_START : SEG_BODY;
      end else begin
        verbatim_q = 1'b0;
        phase_q    = SEG_BODY;
      end
    end else begin
      queue_byte(verbatim_q ? b : rotate_sym(b, 1'b1), b == 8'd0, err_q);
      if (b == 8'd0) phase_q = SEG_START;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     = 1'b0;
      extra_q    = '0;
      user_q     = '0;
      stamp_q    = '0;
      phase_q    = SEG_START;
      slice_q    = '0;
      word_q     = '0;
      verbatim_q = 1'b0;
      err_q      = STAT_OK;
      for (int k = 0; k < 7; k++) prologue_q[k] = '0;
      due_results.delete();
      fail_cnt   = 0;
      checked    = 0;
      ok_cnt     = 0;
      format_cnt = 0;
      check_cnt  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DECODE_MODE: mode_q  = pwdata[0];
          REG_EXTRA_KEY:   extra_q = pwdata[15:0];
          REG_USER_KEY:    user_q  = pwdata[11:0];
          REG_TIME_STAMP:  stamp_q = pwdata[15:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        checked++;
        case (got_status_i)
          STAT_OK:     ok_cnt++;
          STAT_FORMAT: format_cnt++;
          default:     check_cnt++;
        endcase
        if (due_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("unexpected result: byte %h eos %b status %0d",
                     got_byte_i, got_eos_i, got_status_i);
          end
        end else begin
          oldest = due_results.pop_front();
          if (oldest.out_byte != got_byte_i || oldest.end_of_string != got_eos_i ||
              oldest.status != got_status_i) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("mismatch at result %0d: byte %h/%h eos %b/%b status %0d/%0d (exp/got)",
                       checked, oldest.out_byte, got_byte_i, oldest.end_of_string,
                       got_eos_i, oldest.status, got_status_i);
            end
          end
        end
      end
      if (push && !full) derive_results(sent_byte_i, sent_nonce_i);
    end
    fail_cnt_o   <= fail_cnt;
    pending_o    <= due_results.size();
    checked_o    <= checked;
    ok_cnt_o     <= ok_cnt;
    format_cnt_o <= format_cnt;
    check_cnt_o  <= check_cnt;
  end

endmodule

### test/rotating_alphabet_obfuscator_tb.sv
`timescale 1ns / 1ps
// Testbench top for rotating_alphabet_obfuscator: clock, reset, register
// writes, byte stimulus and verdict. Uses rao_pkg and rao_result_checker.
module rotating_alphabet_obfuscator_tb;
  import rao_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int SETTLE = 40;
  localparam int N_RAND = 200;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  push    = 1'b0;
  logic                  full;
  logic [7:0]            in_byte_i = '0;
  logic [3:0]            nonce_i   = '0;
  logic                  empty;
  logic                  pop     = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  end_of_string_o;
  logic [1:0]            status_o;

  int         send_idle = 27;
  int         recv_idle = 60;
  bit         hold_req  = 1'b0;
  int         cycles    = 0;
  int         sent_cnt  = 0;
  logic [7:0] captured [$];
  logic [7:0] replay [$];

  int fail_cnt, pending, checked, ok_cnt, format_cnt, check_cnt;

  rotating_alphabet_obfuscator i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .in_byte_i, .nonce_i, .empty, .pop, .out_byte_o,
    .end_of_string_o, .status_o
  );

  rao_result_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .push, .full, .sent_byte_i(in_byte_i), .sent_nonce_i(nonce_i),
    .empty, .pop, .got_byte_i(out_byte_o), .got_eos_i(end_of_string_o),
    .got_status_i(status_o), .fail_cnt_o(fail_cnt), .pending_o(pending),
    .checked_o(checked), .ok_cnt_o(ok_cnt), .format_cnt_o(format_cnt),
    .check_cnt_o(check_cnt)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : result_drain
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) captured.push_back(out_byte_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic write_reg(input cfg_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic configure(input logic mode, input logic [15:0] ek, input logic [11:0] uk,
                           input logic [15:0] ts);
    write_reg(REG_DECODE_MODE, (32'($urandom) & 32'hfffffffe) | 32'(mode));
    write_reg(REG_EXTRA_KEY, (32'($urandom) & 32'hffff0000) | 32'(ek));
    write_reg(REG_USER_KEY, (32'($urandom) & 32'hfffff000) | 32'(uk));
    write_reg(REG_TIME_STAMP, (32'($urandom) & 32'hffff0000) | 32'(ts));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] b, input logic [3:0] n);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_byte_i <= b;
    nonce_i   <= n;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_text(input string s, input logic [3:0] n0);
    for (int k = 0; k < s.len(); k++) begin
      send_item(s[k], (k == 0) ? n0 : 4'($urandom_range(15)));
    end
    send_item(8'd0, (s.len() == 0) ? n0 : 4'($urandom_range(15)));
  endtask

  // Hold off until the last result is out, then give the key check time to finish.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [7:0] body_byte();
    case ($urandom_range(4))
      0:       return 8'($urandom_range(255, 1));
      1:       return "0" + 8'($urandom_range(9));
      2:       return "A" + 8'($urandom_range(25));
      3:       return "a" + 8'($urandom_range(25));
      default: return "!" + 8'($urandom_range(14));
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick12();
    case ($urandom_range(3))
      0:       return 12'h000;
      1:       return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int          round;
    int          first_rand;
    int          nstr;
    int          len;
    logic [3:0]  n0;
    logic [7:0]  b;
    logic [15:0] ek;
    logic [15:0] dek;
    logic [15:0] ts;
    logic [15:0] dts;
    logic [11:0] uk;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(1'b0, 16'hffff, 12'hfff, 16'hffff);
    send_item(8'hff, 4'hf);
    send_item(8'h80, 4'h3);
    send_item("/", 4'h0);
    send_item("z", 4'h5);
    send_item(8'h00, 4'ha);
    send_item(8'h00, 4'h0);
    settle();
    configure(1'b1, 16'h0000, 12'h000, 16'h0000);
    send_text("", 4'h9);
    send_text(".", 4'h6);
    send_text(".abcde", 4'hc);
    send_text("ABCDEFuq", 4'h1);
    settle();

    first_rand = sent_cnt;
    round      = 0;
    while (sent_cnt - first_rand < N_RAND || round < 4) begin
      if (sent_cnt - first_rand < 70) begin
        send_idle = 27;
        recv_idle = 60;
      end else if (sent_cnt - first_rand < 140) begin
        send_idle = 60;
        recv_idle = 27;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      ek  = pick16();
      uk  = pick12();
      ts  = (round == 0) ? 16'hffff : (round == 1) ? 16'h0000 : pick16();
      configure(1'b0, ek, uk, ts);
      captured.delete();
      if (round == 0) hold_req = 1'b1;
      nstr = $urandom_range(5, 2);
      for (int s = 0; s < nstr; s++) begin
        case (round % 3)
          0:       n0 = (s == 0) ? 4'h0 : 4'($urandom_range(15));
          1:       n0 = (s == 0) ? 4'hf : 4'($urandom_range(15));
          default: n0 = 4'($urandom_range(15));
        endcase
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6);
        for (int k = 0; k < len; k++) begin
          send_item(body_byte(), (k == 0) ? n0 : 4'($urandom_range(15)));
        end
        // leave the last string open once so decode picks up mid-string
        if (!(round == 2 && s == nstr - 1)) begin
          send_item(8'd0, (len == 0) ? n0 : 4'($urandom_range(15)));
        end
      end
      settle();
      replay = captured;

      case ((round == 0 || round == 1) ? round : $urandom_range(4))
        0:       dts = ts + 16'd1;
        1:       dts = ts - 16'd1;
        2:       dts = ts;
        3:       dts = ts + 16'd2;
        default: dts = 16'($urandom);
      endcase
      dek = ($urandom_range(5) == 0) ? (ek ^ 16'h0001) : ek;
      configure(1'b1, dek, uk, dts);
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(8);
        for (int k = 0; k < len; k++) send_item(8'($urandom_range(255, 1)), 4'($urandom));
        send_item(8'd0, 4'($urandom));
      end
      foreach (replay[k]) begin
        b = replay[k];
        if (b != 8'd0 && $urandom_range(39) == 0) b = 8'($urandom_range(255, 1));
        send_item(b, 4'($urandom_range(15)));
      end
      settle();
      round++;
    end

    $display("Covered %0d byte transfers in %0d encode/decode rounds, %0d results checked",
             sent_cnt, round, checked);
    $display("Result status seen: ok %0d, format %0d, check %0d",
             ok_cnt, format_cnt, check_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
